>>> sv/boig_pkg.sv
// Shared package for the bisection order index generator.
// Holds the fixed field widths, the default point limit and the
// controller-to-datapath command and status structs. No dependencies.
package boig_pkg;

    localparam int DEFAULT_MAX_POINTS = 64;
    localparam int COUNT_W            = 7;
    localparam int INDEX_W            = 6;

    // Commands issued by the controller, each decoded from its current state.
    typedef struct packed {
        logic load;       // capture the (saturated) point count
        logic emit_top;   // emit count-1, or 0 for a single point
        logic emit_zero;  // emit 0 and set up the interior slots
        logic scan;       // examine one slot while looking for the longest segment
        logic pick;       // set up the search for the slot to emit
        logic locate;     // examine one slot while searching for that slot
        logic merge;      // merge single-entry segments and restart the scan
    } t_cmd;

    // Status returned by the datapath.
    typedef struct packed {
        logic in_zero;     // point count on the input port is zero
        logic cnt_one;     // captured count is one
        logic cnt_two;     // captured count is two
        logic slot_end;    // slot pointer sits on the last interior slot
        logic hit;         // current slot is the one to emit
        logic next_live;   // current slot is the first live slot after the emitted one in a split
        logic split;       // chosen segment is long enough to be split
        logic final_drop;  // only one interior entry is left
    } t_status;

endpackage

>>> sv/bisection_order_index_generator.sv
// Top level of the bisection order index generator.
// Instantiates the controller (boig_ctrl) and the datapath (boig_dpath).
// Depends on boig_pkg.
//
//  Channel   | Direction | Handshake                 | Payload
//  ----------+-----------+---------------------------+------------------------------
//  command   | in        | start, busy               | i_point_count[6:0]
//  result    | out       | o_valid (one-cycle strobe)| o_point_index[5:0], o_last
//
// An item is taken at a rising edge with start high and busy low. The count
// saturates at MAX_POINTS; a count of zero produces no result and busy stays
// low. Every index below the count is then sent once, one result per strobe,
// with o_last marking the final one. The receiver cannot stall the block:
// each result is on the ports for exactly one cycle.
//
// Sequence: the first two results (count-1 and 0) are sent from states of
// their own. Each interior index (m = count-2 of them) costs one pass of the
// slot pointer over all m slots to find the first longest segment, a setup
// step, a walk from the start of that segment to the emitted slot (and for a
// split on to the next live slot), and a merge step (none after the final index).
//
// Reset is synchronous and active low; it clears the state machine, the live
// and segment-start marks and the result strobe. No clearing pass is needed.
module bisection_order_index_generator
    import boig_pkg::*;
#(
    parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [COUNT_W-1:0] i_point_count,
    output logic               o_valid,
    output logic [INDEX_W-1:0] o_point_index,
    output logic               o_last
);

    t_cmd    cmd;
    t_status status;

    // The controller only steps through the phases; all bookkeeping of
    // segments lives in the datapath.
    boig_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // The datapath holds one live mark and one segment-start mark per
    // interior slot. The value held by a slot is always its position plus
    // one, so no separate value memory is kept.
    boig_dpath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_point_count (i_point_count),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_point_index (o_point_index),
        .o_last        (o_last)
    );

    // Results are only launched from an active run, so an idle cycle is
    // never followed by a strobe.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |=> !o_valid)
        else $error("result strobe after an idle cycle");

    // The final flag only ever accompanies a result.
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid)
        else $error("last flag without a result strobe");

endmodule

>>> sv/boig_ctrl.sv
// Controller state machine for the bisection order index generator.
// Sequences emission, scan, pick, locate and merge steps of the datapath.
// Depends on boig_pkg.
module boig_ctrl
    import boig_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_EMIT_TOP  = 7'b0000010,
        S_EMIT_ZERO = 7'b0000100,
        S_SCAN      = 7'b0001000,
        S_PICK      = 7'b0010000,
        S_LOCATE    = 7'b0100000,
        S_MERGE     = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
                if (start && !i_status.in_zero) begin
                    n_state = S_EMIT_TOP;
                end
            end
            S_EMIT_TOP: begin
                o_cmd.emit_top = 1'b1;
                n_state = i_status.cnt_one ? S_IDLE : S_EMIT_ZERO;
            end
            S_EMIT_ZERO: begin
                o_cmd.emit_zero = 1'b1;
                n_state = i_status.cnt_two ? S_IDLE : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.slot_end) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state = S_LOCATE;
            end
            S_LOCATE: begin
                o_cmd.locate = 1'b1;
                if (i_status.hit) begin
                    if (i_status.final_drop) begin
                        n_state = S_IDLE;
                    end else if (!i_status.split || i_status.slot_end) begin
                        n_state = S_MERGE;
                    end
                end else if (i_status.next_live || i_status.slot_end) begin
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
                n_state = S_SCAN;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    // The final interior entry never leaves a split pending.
    a_final_no_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOCATE && i_status.hit && i_status.final_drop) |-> !i_status.split)
        else $error("final drop found in a segment that is being split");

    // A run always opens with the top index right after the item is taken.
    a_run_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && start && !i_status.in_zero) |=> (r_state == S_EMIT_TOP))
        else $error("accepted item did not start with the top index");

endmodule

>>> sv/boig_dpath.sv
// Datapath for the bisection order index generator: live and segment-start
// mark vectors, slot pointer, scan and locate registers, result registers.
// Depends on boig_pkg.
module boig_dpath
    import boig_pkg::*;
#(
    parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [COUNT_W-1:0] i_point_count,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    output logic               o_valid,
    output logic [INDEX_W-1:0] o_point_index,
    output logic               o_last
);

    localparam int IW = $clog2(MAX_POINTS);

    // Control state.
    logic [MAX_POINTS-1:0] r_live,  n_live;
    logic [MAX_POINTS-1:0] r_start, n_start;
    logic [IW-1:0]         r_remain, n_remain;
    logic                  r_valid, n_valid;
    logic                  r_last,  n_last;
    logic                  r_found, n_found;

    // Payload state.
    logic [COUNT_W-1:0] r_count, n_count;
    logic [IW-1:0]      r_last_slot, n_last_slot;
    logic [IW-1:0]      r_slot, n_slot;
    logic [IW-1:0]      r_cur_first, n_cur_first;
    logic [IW-1:0]      r_cur_len, n_cur_len;
    logic [IW-1:0]      r_best_first, n_best_first;
    logic [IW-1:0]      r_best_len, n_best_len;
    logic [IW-1:0]      r_seen, n_seen;
    logic [IW-1:0]      r_target, n_target;
    logic               r_split, n_split;
    logic [INDEX_W-1:0] r_index, n_index;

    logic [COUNT_W-1:0]    interior;
    logic [MAX_POINTS-1:0] init_live;
    logic [IW-1:0]         len_inc;
    logic                  slot_live;
    logic                  hit;
    logic                  next_live;
    logic                  any_multi;

    assign interior  = r_count - COUNT_W'(2);
    assign slot_live = r_live[r_slot];
    assign hit       = slot_live && !r_found && (r_seen == r_target);
    assign next_live = slot_live && r_found;
    assign any_multi = |(r_live & ~r_start);
    assign len_inc   = r_start[r_slot] ? IW'(1) : (r_cur_len + IW'(1));

    always_comb begin
        for (int j = 0; j < MAX_POINTS; j++) begin
            init_live[j] = (COUNT_W'(j) < interior);
        end
    end

    always_comb begin
        n_live       = r_live;
        n_start      = r_start;
        n_remain     = r_remain;
        n_valid      = 1'b0;
        n_last       = 1'b0;
        n_found      = r_found;
        n_count      = r_count;
        n_last_slot  = r_last_slot;
        n_slot       = r_slot;
        n_cur_first  = r_cur_first;
        n_cur_len    = r_cur_len;
        n_best_first = r_best_first;
        n_best_len   = r_best_len;
        n_seen       = r_seen;
        n_target     = r_target;
        n_split      = r_split;
        n_index      = r_index;

        if (i_cmd.load) begin
            n_count = (i_point_count > COUNT_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS)
                                                             : i_point_count;
        end

        if (i_cmd.emit_top) begin
            n_valid = 1'b1;
            n_last  = (r_count == COUNT_W'(1));
            n_index = (r_count == COUNT_W'(1)) ? '0 : INDEX_W'(r_count - COUNT_W'(1));
        end

        if (i_cmd.emit_zero) begin
            n_valid     = 1'b1;
            n_last      = (r_count == COUNT_W'(2));
            n_index     = '0;
            n_live      = init_live;
            n_start     = '0;
            n_start[0]  = (r_count > COUNT_W'(2));
            n_remain    = IW'(interior);
            n_last_slot = IW'(r_count - COUNT_W'(3));
        end

        if (i_cmd.scan && slot_live) begin
            n_cur_len = len_inc;
            if (r_start[r_slot]) begin
                n_cur_first = r_slot;
            end
            if (len_inc > r_best_len) begin
                n_best_len   = len_inc;
                n_best_first = r_start[r_slot] ? r_slot : r_cur_first;
            end
        end
        if (i_cmd.scan || i_cmd.locate) begin
            n_slot = r_slot + IW'(1);
        end

        if (i_cmd.pick) begin
            n_slot   = r_best_first;
            n_seen   = '0;
            n_found  = 1'b0;
            n_split  = (r_best_len > IW'(2));
            // A short segment gives up its last entry, a longer one its middle.
            n_target = (r_best_len > IW'(2)) ? (r_best_len >> 1) : (r_best_len - IW'(1));
        end

        if (i_cmd.locate) begin
            if (slot_live && !r_found) begin
                n_seen = r_seen + IW'(1);
            end
            if (hit) begin
                n_valid         = 1'b1;
                n_last          = (r_remain == IW'(1));
                n_index         = INDEX_W'(r_slot) + INDEX_W'(1);
                n_live[r_slot]  = 1'b0;
                n_start[r_slot] = 1'b0;
                n_remain        = r_remain - IW'(1);
                n_found         = 1'b1;
            end
            if (next_live && r_split) begin
                n_start[r_slot] = 1'b1;
            end
        end

        if (i_cmd.merge) begin
            if (!any_multi) begin
                // Keep only the lowest live slot as a segment start.
                n_start = r_live & (~r_live + MAX_POINTS'(1));
            end
        end

        if (i_cmd.emit_zero || i_cmd.merge) begin
            n_slot       = '0;
            n_cur_first  = '0;
            n_cur_len    = '0;
            n_best_first = '0;
            n_best_len   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live   <= '0;
            r_start  <= '0;
            r_remain <= '0;
            r_valid  <= 1'b0;
            r_last   <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_live   <= n_live;
            r_start  <= n_start;
            r_remain <= n_remain;
            r_valid  <= n_valid;
            r_last   <= n_last;
            r_found  <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count      <= n_count;
        r_last_slot  <= n_last_slot;
        r_slot       <= n_slot;
        r_cur_first  <= n_cur_first;
        r_cur_len    <= n_cur_len;
        r_best_first <= n_best_first;
        r_best_len   <= n_best_len;
        r_seen       <= n_seen;
        r_target     <= n_target;
        r_split      <= n_split;
        r_index      <= n_index;
    end

    assign o_status.in_zero    = (i_point_count == '0);
    assign o_status.cnt_one    = (r_count == COUNT_W'(1));
    assign o_status.cnt_two    = (r_count == COUNT_W'(2));
    assign o_status.slot_end   = (r_slot == r_last_slot);
    assign o_status.hit        = hit;
    assign o_status.next_live  = next_live && r_split;
    assign o_status.split      = r_split;
    assign o_status.final_drop = (r_remain == IW'(1));

    assign o_valid       = r_valid;
    assign o_point_index = r_index;
    assign o_last        = r_last;

    // The remaining count always matches the number of live slots.
    a_remain_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_remain) == 32'($countones(r_live))))
        else $error("remaining count differs from live slot count");

    // A segment start mark is only ever carried by a live slot.
    a_start_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_start & ~r_live) == '0))
        else $error("segment start mark on a slot that is not live");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for bisection_order_index_generator.
// Holds a driver, a result monitor and a bisection-order predictor.
// Depends on boig_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
    import boig_pkg::*;

    localparam int MAX_PTS   = DEFAULT_MAX_POINTS;
    localparam int N_RANDOM  = 116;
    // Quiet cycles after the last expected index, in case a stray strobe follows it.
    localparam int TAIL_WAIT = 200;

    // One expected result: an index and whether it closes the run.
    typedef struct {
        logic [INDEX_W-1:0] index;
        logic               is_last;
    } t_order_entry;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [COUNT_W-1:0] i_point_count = '0;
    logic               o_valid;
    logic [INDEX_W-1:0] o_point_index;
    logic               o_last;

    // Counts waiting to be sent, and the indices still owed by the block, oldest first.
    logic [COUNT_W-1:0] pending_counts[$];
    t_order_entry       owed_indices[$];

    // Driver bookkeeping. The driver writes these, but for total_items, which the stimulus block sets.
    logic               holding = 1'b0;
    int                 items_taken = 0;
    int                 total_items = 0;
    int                 largest_count = 0;

    // Monitor bookkeeping.
    int                 indices_checked = 0;
    int                 runs_closed = 0;
    int                 error_count = 0;

    bisection_order_index_generator #(
        .MAX_POINTS(MAX_PTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_point_count(i_point_count),
        .o_valid      (o_valid),
        .o_point_index(o_point_index),
        .o_last       (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Works out the full bisection order for one count and appends it to the
    // owed list. Interior slot i always holds index i+1, so only the live and
    // segment-head marks need to be tracked.
    function automatic void queue_bisection_order(input logic [COUNT_W-1:0] cnt);
        int             n, m, i, p, left, segs, half, seen;
        int             cur_first, cur_len, best_first, best_len;
        bit             live[MAX_PTS];
        bit             head[MAX_PTS];
        bit             all_single, first_live, finished;
        int             order[$];
        t_order_entry   entry;

        n = (cnt > MAX_PTS) ? MAX_PTS : int'(cnt);
        if (n == 0) begin
            return;
        end
        if (n == 1) begin
            order = {order, 0};
        end else begin
            order = {order, n - 1};
            order = {order, 0};
        end
        if (n > 2) begin
            m = n - 2;
            for (i = 0; i < MAX_PTS; i++) begin
                live[i] = (i < m);
                head[i] = (i == 0);
            end
            left = m;
            finished = 1'b0;
            while (left > 0 && !finished) begin
                segs = 0;
                cur_first = 0;
                cur_len = 0;
                best_first = 0;
                best_len = 0;
                // Find the first of the longest segments.
                for (i = 0; i < m; i++) begin
                    if (live[i]) begin
                        if (head[i]) begin
                            segs++;
                            cur_first = i;
                            cur_len = 0;
                        end
                        cur_len++;
                        if (cur_len > best_len) begin
                            best_len = cur_len;
                            best_first = cur_first;
                        end
                    end
                end
                if (best_len == 0) begin
                    finished = 1'b1;
                end else if (segs == 1 && best_len == 1) begin
                    // A lone one-entry segment closes the run.
                    order = {order, best_first + 1};
                    left--;
                    finished = 1'b1;
                end else begin
                    if (best_len <= 2) begin
                        // Short segment: take its last live entry.
                        seen = 0;
                        p = best_first;
                        for (i = best_first; i < m && seen < best_len; i++) begin
                            if (live[i]) begin
                                seen++;
                                p = i;
                            end
                        end
                        order = {order, p + 1};
                        live[p] = 1'b0;
                        head[p] = 1'b0;
                        left--;
                    end else begin
                        // Long segment: take the middle entry and split there.
                        half = best_len / 2;
                        seen = 0;
                        p = best_first;
                        for (i = best_first; i < m; i++) begin
                            if (live[i]) begin
                                if (seen == half) begin
                                    p = i;
                                    break;
                                end
                                seen++;
                            end
                        end
                        order = {order, p + 1};
                        live[p] = 1'b0;
                        head[p] = 1'b0;
                        left--;
                        for (i = p + 1; i < m; i++) begin
                            if (live[i]) begin
                                head[i] = 1'b1;
                                break;
                            end
                        end
                    end
                    // Once every segment is down to one entry they fuse into one.
                    all_single = 1'b1;
                    for (i = 0; i < m; i++) begin
                        if (live[i] && !head[i]) begin
                            all_single = 1'b0;
                        end
                    end
                    if (all_single && left > 0) begin
                        first_live = 1'b1;
                        for (i = 0; i < m; i++) begin
                            head[i] = 1'b0;
                            if (live[i] && first_live) begin
                                head[i] = 1'b1;
                                first_live = 1'b0;
                            end
                        end
                    end
                end
            end
        end
        foreach (order[k]) begin
            entry.index   = order[k][INDEX_W-1:0];
            entry.is_last = (k == order.size() - 1);
            owed_indices = {owed_indices, entry};
        end
    endfunction

    // Driver. It holds one count at a time and offers it by raising start on
    // the cycles it does not idle. The block takes the item at an edge where
    // start is high and busy is low; the expected indices are queued right
    // there. The idle rate follows the phase: 18 percent for the first third
    // of the items, 71 percent for the second, none for the rest. Because the
    // offer is re-decided every cycle, gaps land on all points of a run,
    // including the cycle where busy falls.
    always @(posedge i_clk) begin
        int idle_pct;
        if (!i_rst_n) begin
            start <= 1'b0;
            holding = 1'b0;
        end else begin
            if (start && !busy) begin
                queue_bisection_order(i_point_count);
                if (int'(i_point_count) > largest_count) begin
                    largest_count = int'(i_point_count);
                end
                items_taken++;
                holding = 1'b0;
            end
            if (!holding && pending_counts.size() > 0) begin
                i_point_count <= pending_counts.pop_front();
                holding = 1'b1;
            end
            if (items_taken < total_items / 3) begin
                idle_pct = 18;
            end else if (items_taken < (2 * total_items) / 3) begin
                idle_pct = 71;
            end else begin
                idle_pct = 0;
            end
            start <= holding && ($urandom_range(99) >= idle_pct);
        end
    end

    // Monitor. Every strobe is one result and must match the oldest owed index.
    always @(posedge i_clk) begin
        t_order_entry want;
        if (i_rst_n && o_valid) begin
            if (owed_indices.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual index %0d last %0b",
                         $time, o_point_index, o_last);
                error_count++;
            end else begin
                want = owed_indices.pop_front();
                if (o_point_index !== want.index) begin
                    $display("%0t: point_index mismatch: expected %0d, actual %0d",
                             $time, want.index, o_point_index);
                    error_count++;
                end
                if (o_last !== want.is_last) begin
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, want.is_last, o_last);
                    error_count++;
                end
                indices_checked++;
                if (want.is_last) begin
                    runs_closed++;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        logic [COUNT_W-1:0] directed[$];
        int                 pick;
        int                 quiet;

        // Directed counts: empty, the one- and two-point cases, small runs of
        // every shape, powers of two and their neighbors, the full size, and
        // counts above the limit that must saturate (up to all bits of the field set).
        directed = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd9,
                     7'd10, 7'd11, 7'd16, 7'd17, 7'd31, 7'd32, 7'd33, 7'd63, 7'd64,
                     7'd65, 7'd96, 7'd127, 7'd0, 7'd1};
        foreach (directed[k]) begin
            pending_counts = {pending_counts, directed[k]};
        end

        // Random counts, mostly short runs, with a few full-size and saturating ones.
        for (int k = 0; k < N_RANDOM; k++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                pending_counts = {pending_counts, 7'd0};
            end else if (pick < 60) begin
                pending_counts = {pending_counts, COUNT_W'($urandom_range(16, 1))};
            end else if (pick < 88) begin
                pending_counts = {pending_counts, COUNT_W'($urandom_range(40, 17))};
            end else if (pick < 96) begin
                pending_counts = {pending_counts, COUNT_W'($urandom_range(64, 41))};
            end else begin
                pending_counts = {pending_counts, COUNT_W'($urandom_range(127, 65))};
            end
        end
        total_items = pending_counts.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every item is taken and every owed index has come back.
        do begin
            @(posedge i_clk);
        end while (pending_counts.size() > 0 || holding || owed_indices.size() > 0);

        // Watch a little longer for anything the block should not send.
        for (quiet = 0; quiet < TAIL_WAIT; quiet++) begin
            @(posedge i_clk);
        end

        $display("Sent %0d point counts (largest %0d), checked %0d indices over %0d runs.",
                 items_taken, largest_count, indices_checked, runs_closed);
        $display("Idle phases covered: 18%%, 71%% and none on the command side.");
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Watchdog, far above the slowest correct run.
    initial begin
        #100_000_000;
        $display("%0t: timeout with %0d items pending and %0d indices owed",
                 $time, pending_counts.size(), owed_indices.size());
        $display("tb_top: errors");
        $finish;
    end

endmodule
